// ----- rtl/separated_decimal_field_parser_macros.svh -----
// Assertion macros for the separated decimal field parser.
// Expects clk and arst_n in the scope of use.
`ifndef SEPARATED_DECIMAL_FIELD_PARSER_MACROS_SVH
`define SEPARATED_DECIMAL_FIELD_PARSER_MACROS_SVH

// same-cycle implication
`define SDFP_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SDFP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/sdfp_pkg.sv -----
// Shared types and constants of the separated decimal field parser.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sdfp_pkg;

	localparam logic [7:0]  CH_NEWLINE = 8'h0A;
	localparam logic [7:0]  CH_DOT     = 8'h2E;
	localparam logic [7:0]  CH_SPACE   = 8'h20;
	localparam logic [7:0]  CH_ZERO    = 8'h30;

	localparam logic [2:0]  BYTE_LIMIT = 3'd3;
	localparam logic [2:0]  WORD_LIMIT = 3'd5;
	localparam logic [15:0] BYTE_MASK  = 16'h00FF;
	localparam logic [15:0] WORD_MASK  = 16'hFFFF;

	localparam logic        REG_WORD_MODE  = 1'b0;
	localparam logic        REG_MAX_FIELDS = 1'b1;
	localparam logic [7:0]  MAX_FIELDS_RST = 8'd4;

	localparam int          RQ_DEPTH = 4;
	localparam int          RQ_AW    = $clog2(RQ_DEPTH);
	localparam int          RQ_CW    = $clog2(RQ_DEPTH + 1);

	typedef struct packed {
		logic [15:0] value;
		logic [7:0]  index;
		logic        has_value;
		logic        eor;
		logic [7:0]  count;
	} res_t;

	typedef struct packed {
		logic [15:0] acc;
		logic [2:0]  dc;
		logic [7:0]  sc;
		logic        ended;
	} state_t;

	// up to two results of one item, in order; v1 implies v0
	typedef struct packed {
		logic v0;
		logic v1;
		res_t r0;
		res_t r1;
	} push_t;

endpackage

`default_nettype wire

// ----- rtl/sdfp_step.sv -----
// Per-item parse logic: next state and up to two results.
// Depends on sdfp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sdfp_step (
	input  wire logic [7:0]      char_in,
	input  wire logic            last_char,
	input  wire logic            word_mode,
	input  wire logic [7:0]      max_fields,
	input  wire sdfp_pkg::state_t cur,
	output sdfp_pkg::state_t     nxt,
	output sdfp_pkg::push_t      push
);

	function automatic sdfp_pkg::res_t end_res(input logic [7:0] sc, input logic [15:0] acc,
			input logic [7:0] maxf, input logic [15:0] mask);
		sdfp_pkg::res_t r;
		r.eor   = 1'b1;
		r.index = sc;
		if (sc < maxf) begin
			r.value     = acc & mask;
			r.has_value = 1'b1;
			r.count     = sc + 8'd1;
		end else begin
			r.value     = 16'h0000;
			r.has_value = 1'b0;
			r.count     = sc;
		end
		return r;
	endfunction

	logic [15:0]      mask;
	logic [2:0]       limit;
	logic             sep;
	logic [15:0]      acc_mul;
	sdfp_pkg::res_t   e;

	assign mask  = word_mode ? sdfp_pkg::WORD_MASK : sdfp_pkg::BYTE_MASK;
	assign limit = word_mode ? sdfp_pkg::WORD_LIMIT : sdfp_pkg::BYTE_LIMIT;
	assign sep   = (char_in == sdfp_pkg::CH_SPACE) ||
	               (!word_mode && char_in == sdfp_pkg::CH_DOT);
	assign acc_mul = {cur.acc[12:0], 3'b000} + {cur.acc[14:0], 1'b0} +
	                 ({8'h00, char_in} - {8'h00, sdfp_pkg::CH_ZERO});

	always_comb begin
		nxt  = cur;
		push = '0;
		e    = '0;
		if (!cur.ended) begin
			if (char_in == sdfp_pkg::CH_NEWLINE) begin
				push.r0 = end_res(cur.sc, cur.acc, max_fields, mask);
				push.v0 = 1'b1;
				nxt.sc    = push.r0.count;
				nxt.acc   = 16'h0000;
				nxt.dc    = 3'd0;
				nxt.ended = 1'b1;
			end else begin
				if (!sep && cur.dc < limit) begin
					nxt.acc = acc_mul & mask;
					nxt.dc  = cur.dc + 3'd1;
				end else begin
					if (cur.sc < max_fields) begin
						push.r0.value     = cur.acc & mask;
						push.r0.index     = cur.sc;
						push.r0.has_value = 1'b1;
						push.r0.eor       = 1'b0;
						push.r0.count     = 8'd0;
						push.v0           = 1'b1;
						nxt.sc            = cur.sc + 8'd1;
					end
					nxt.acc = 16'h0000;
					nxt.dc  = 3'd0;
				end
				if (last_char) begin
					e = end_res(nxt.sc, nxt.acc, max_fields, mask);
					if (push.v0) begin
						push.r1 = e;
						push.v1 = 1'b1;
					end else begin
						push.r0 = e;
						push.v0 = 1'b1;
					end
				end
			end
		end
		if (last_char) begin
			nxt = '0;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/sdfp_rq.sv -----
// Result queue: takes up to two results a cycle, hands out one.
// Depends on sdfp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sdfp_rq (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire sdfp_pkg::push_t push,
	input  wire logic            pop,
	output logic                 head_valid,
	output sdfp_pkg::res_t       head,
	output logic                 room
);

	sdfp_pkg::res_t                 mem_q [sdfp_pkg::RQ_DEPTH];
	logic [sdfp_pkg::RQ_AW-1:0]     wp_q;
	logic [sdfp_pkg::RQ_AW-1:0]     rp_q;
	logic [sdfp_pkg::RQ_CW-1:0]     cnt_q;
	logic [sdfp_pkg::RQ_CW-1:0]     n_push;

	assign n_push     = sdfp_pkg::RQ_CW'(push.v0) + sdfp_pkg::RQ_CW'(push.v1);
	assign head_valid = (cnt_q != '0);
	assign head       = mem_q[rp_q];
	// room for two more, judged on the registered count only
	assign room       = (cnt_q <= sdfp_pkg::RQ_CW'(sdfp_pkg::RQ_DEPTH - 2));

	always_ff @(posedge clk) begin
		if (push.v0) begin
			mem_q[wp_q] <= push.r0;
		end
		if (push.v1) begin
			mem_q[wp_q + sdfp_pkg::RQ_AW'(1)] <= push.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			wp_q  <= wp_q + n_push[sdfp_pkg::RQ_AW-1:0];
			if (pop) begin
				rp_q <= rp_q + sdfp_pkg::RQ_AW'(1);
			end
			cnt_q <= cnt_q + n_push - sdfp_pkg::RQ_CW'(pop);
		end
	end

endmodule

`default_nettype wire

// ----- rtl/separated_decimal_field_parser.sv -----
// An item is registered in the input stage and parsed there; its results are written into
// the result queue and offered from its head.
// Throughput: one item per cycle while items give at most one result; an item with two
// results is handed out one result at a time. Input is held off when the four-entry result
// queue has fewer than two free slots.
// Reset (arst_n low, asynchronous): parse state cleared, word_mode 0, max_fields 4.
`timescale 1ns / 1ps
`default_nettype none
`include "separated_decimal_field_parser_macros.svh"

module separated_decimal_field_parser (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // char_in
	input  wire logic        s_tlast,   // last_char
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,   // field_value[15:0], field_index[23:16], field_count[31:24]
	output logic             m_tlast,   // end_of_record
	output logic             m_tuser,   // has_value
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        cfg_index,
	input  wire logic [7:0]  cfg_data
);

	logic               v_s1;
	logic [7:0]         char_s1;
	logic               last_s1;
	logic               word_mode_q;
	logic [7:0]         max_fields_q;
	sdfp_pkg::state_t   state_q;
	sdfp_pkg::state_t   state_nxt;
	sdfp_pkg::push_t    step_push;
	sdfp_pkg::push_t    rq_push;
	sdfp_pkg::res_t     head;
	logic               room;
	logic               adv;

	assign cfg_ready = 1'b1;
	assign adv       = v_s1 && room;
	assign s_tready  = !v_s1 || room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_mode_q  <= 1'b0;
			max_fields_q <= sdfp_pkg::MAX_FIELDS_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				sdfp_pkg::REG_WORD_MODE:  word_mode_q  <= cfg_data[0];
				sdfp_pkg::REG_MAX_FIELDS: max_fields_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tready) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			char_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (adv) begin
			state_q <= state_nxt;
		end
	end

	sdfp_step u_step (
		.char_in    (char_s1),
		.last_char  (last_s1),
		.word_mode  (word_mode_q),
		.max_fields (max_fields_q),
		.cur        (state_q),
		.nxt        (state_nxt),
		.push       (step_push)
	);

	always_comb begin
		rq_push    = step_push;
		rq_push.v0 = step_push.v0 && adv;
		rq_push.v1 = step_push.v1 && adv;
	end

	sdfp_rq u_rq (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (rq_push),
		.pop        (m_tvalid && m_tready),
		.head_valid (m_tvalid),
		.head       (head),
		.room       (room)
	);

	assign m_tdata = {head.count, head.index, head.value};
	assign m_tlast = head.eor;
	assign m_tuser = head.has_value;

	`SDFP_ASSERT_NOW(a_end_count, m_tvalid && m_tlast && m_tuser, m_tdata[31:24] == m_tdata[23:16] + 8'd1, "end item with value has wrong count")
	`SDFP_ASSERT_NOW(a_novalue_end, m_tvalid && !m_tuser, m_tlast && m_tdata[15:0] == 16'h0000, "item without value is not an empty end item")
	`SDFP_ASSERT_NEXT(a_last_clears, adv && last_s1, state_q == '0, "parse state not cleared after last item")

endmodule

`default_nettype wire

// ----- tb/tb_separated_decimal_field_parser.sv -----
// Self-checking testbench for separated_decimal_field_parser: streams text records,
// predicts the field results in a scoreboard class and checks every output item.
// Depends on sdfp_pkg and the parser RTL.
`timescale 1ns / 1ps

module tb_separated_decimal_field_parser;

	localparam int IDLE_LIMIT = 4000;
	localparam int HOLD_CYCLES = 400;

	class field_scoreboard;
		logic        word_mode;
		logic [7:0]  max_fields;
		logic [15:0] acc;
		logic [2:0]  digits;
		logic [7:0]  stored;
		logic        closed;
		sdfp_pkg::res_t expected_q[$];
		int          errors;

		function new();
			word_mode = 1'b0;
			max_fields = sdfp_pkg::MAX_FIELDS_RST;
			errors = 0;
			clear_parse();
		endfunction

		function void clear_parse();
			acc = '0;
			digits = '0;
			stored = '0;
			closed = 1'b0;
		endfunction

		function logic [15:0] field_mask();
			return word_mode ? sdfp_pkg::WORD_MASK : sdfp_pkg::BYTE_MASK;
		endfunction

		function void set_reg(logic idx, logic [7:0] val);
			if (idx == sdfp_pkg::REG_WORD_MODE)
				word_mode = val[0];
			else
				max_fields = val;
		endfunction

		function void store_field();
			sdfp_pkg::res_t r;
			if (stored < max_fields) begin
				r.value = acc & field_mask();
				r.index = stored;
				r.has_value = 1'b1;
				r.eor = 1'b0;
				r.count = '0;
				expected_q.push_back(r);
				stored++;
			end
			acc = '0;
			digits = '0;
		endfunction

		function void close_record();
			sdfp_pkg::res_t r;
			r.eor = 1'b1;
			r.index = stored;
			if (stored < max_fields) begin
				r.value = acc & field_mask();
				r.has_value = 1'b1;
				stored++;
			end else begin
				r.value = '0;
				r.has_value = 1'b0;
			end
			r.count = stored;
			expected_q.push_back(r);
			acc = '0;
			digits = '0;
			closed = 1'b1;
		endfunction

		// one accepted input item
		function void note_char(logic [7:0] c, logic last);
			logic       sep;
			logic [2:0] lim;
			if (!closed) begin
				if (c == sdfp_pkg::CH_NEWLINE) begin
					close_record();
				end else begin
					sep = (c == sdfp_pkg::CH_SPACE) ||
						(!word_mode && c == sdfp_pkg::CH_DOT);
					lim = word_mode ? sdfp_pkg::WORD_LIMIT : sdfp_pkg::BYTE_LIMIT;
					if (!sep && digits < lim) begin
						acc = (acc * 16'd10 + ({8'd0, c} - {8'd0, sdfp_pkg::CH_ZERO}))
							& field_mask();
						digits++;
					end else begin
						store_field();
					end
					if (last)
						close_record();
				end
			end
			if (last)
				clear_parse();
		endfunction

		function void compare(string name, logic [15:0] want_v, logic [15:0] got_v);
			if (want_v != got_v) begin
				$display("%0t: %s expected %0d got %0d", $time, name, want_v, got_v);
				errors++;
			end
		endfunction

		function void check_result(logic [31:0] data, logic eor, logic hv);
			sdfp_pkg::res_t got;
			sdfp_pkg::res_t want;
			got.value = data[15:0];
			got.index = data[23:16];
			got.count = data[31:24];
			got.has_value = hv;
			got.eor = eor;
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected item value %0d index %0d eor %0d", $time,
					got.value, got.index, got.eor);
				errors++;
				return;
			end
			want = expected_q.pop_front();
			compare("field_value", want.value, got.value);
			compare("field_index", {8'd0, want.index}, {8'd0, got.index});
			compare("has_value", {15'd0, want.has_value}, {15'd0, got.has_value});
			compare("end_of_record", {15'd0, want.eor}, {15'd0, got.eor});
			compare("field_count", {8'd0, want.count}, {8'd0, got.count});
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic        m_tlast;
	logic        m_tuser;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_index = 1'b0;
	logic [7:0]  cfg_data = '0;

	field_scoreboard sb = new();

	int burst_left = 0;
	int chars_sent = 0;
	int hold_requests = 0;
	int holds_done = 0;
	int hold_left = 0;
	int rx_style = 0;
	int rx_left = 0;
	int rx_tick = 0;
	int idle_cycles = 0;

	separated_decimal_field_parser uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.m_tuser(m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #6 clk = ~clk;

	// receiver: stall pattern is redrawn at random when its run ends; long hold on request
	always @(posedge clk) begin
		if (arst_n) begin
			rx_tick <= rx_tick + 1;
			if (rx_left == 0) begin
				rx_style <= $urandom_range(0, 3);
				rx_left <= $urandom_range(16, 96);
			end else begin
				rx_left <= rx_left - 1;
			end
			if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				m_tready <= 1'b0;
			end else if (holds_done != hold_requests) begin
				holds_done <= holds_done + 1;
				hold_left <= HOLD_CYCLES;
				m_tready <= 1'b0;
			end else begin
				case (rx_style)
					0: m_tready <= 1'b1;
					1: m_tready <= 1'($urandom_range(0, 1));
					2: m_tready <= ($urandom_range(0, 3) == 0);
					default: m_tready <= (rx_tick % 8) < 5;
				endcase
			end
		end
	end

	// handshake monitor and watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready)
				sb.check_result(m_tdata, m_tlast, m_tuser);
			if (s_tvalid && s_tready)
				sb.note_char(s_tdata, s_tlast);
			if (cfg_valid && cfg_ready)
				sb.set_reg(cfg_index, cfg_data);
			if ((m_tvalid && m_tready) || (s_tvalid && s_tready) || (cfg_valid && cfg_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("separated_decimal_field_parser test failed");
				$finish;
			end
		end
	end

	task automatic send_char(input logic [7:0] c, input logic last);
		int gap;
		bit drain;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 120)
				: $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			drain = ($urandom_range(0, 60) == 0);
			if (gap != 0 || drain)
				s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
			if (drain)
				while (sb.pending() != 0) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= c;
		s_tlast <= last;
		do @(posedge clk); while (!s_tready);
		burst_left--;
		chars_sent++;
	endtask

	task automatic send_text(input string s, input bit end_last);
		for (int i = 0; i < s.len(); i++)
			send_char(s[i], end_last && (i == s.len() - 1));
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [7:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [7:0] digit_char();
		if ($urandom_range(0, 11) == 0)
			return 8'($urandom_range(0, 255));
		return 8'($urandom_range(sdfp_pkg::CH_ZERO, sdfp_pkg::CH_ZERO + 9));
	endfunction

	function automatic logic [7:0] sep_char();
		if (sb.word_mode || $urandom_range(0, 1))
			return sdfp_pkg::CH_SPACE;
		return sdfp_pkg::CH_DOT;
	endfunction

	// record with random content and a random way of ending
	task automatic send_record();
		int nf;
		int nd;
		int lim;
		int junk;
		lim = sb.word_mode ? 5 : 3;
		nf = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 5);
		for (int f = 0; f < nf; f++) begin
			nd = ($urandom_range(0, 7) == 0) ? lim + 1 : $urandom_range(0, lim);
			for (int d = 0; d < nd; d++)
				send_char(digit_char(), 1'b0);
			if (f != nf - 1)
				send_char(sep_char(), 1'b0);
		end
		case ($urandom_range(0, 3))
			0: send_char(digit_char(), 1'b1);
			1: send_char(sep_char(), 1'b1);
			2: begin
				send_char(sdfp_pkg::CH_NEWLINE, 1'b0);
				junk = $urandom_range(0, 3);
				for (int j = 0; j < junk; j++)
					send_char(8'($urandom_range(0, 255)), 1'b0);
				send_char(8'($urandom_range(0, 255)), 1'b1);
				chars_sent -= junk + 1;
			end
			default: send_char(sdfp_pkg::CH_NEWLINE, 1'b1);
		endcase
	endtask

	task automatic send_noise();
		int n;
		n = $urandom_range(4, 16);
		for (int i = 0; i < n; i++)
			send_char(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
	endtask

	initial begin
		int target;
		logic wm;
		logic [7:0] mf;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: byte fields, four per record
		send_text("255.9999 A\n", 1'b0);
		send_text("x", 1'b1);
		send_char(8'h00, 1'b0);
		send_char(8'hFF, 1'b0);
		send_text(".", 1'b1);
		wait_drained();
		write_reg(sdfp_pkg::REG_WORD_MODE, 8'd1);
		write_reg(sdfp_pkg::REG_MAX_FIELDS, 8'd1);
		send_text("65535 7", 1'b1);
		// word field left open, then finished in byte mode
		wait_drained();
		write_reg(sdfp_pkg::REG_MAX_FIELDS, 8'd255);
		send_text("1234", 1'b0);
		wait_drained();
		write_reg(sdfp_pkg::REG_WORD_MODE, 8'd0);
		send_text("5\n", 1'b1);
		wait_drained();
		write_reg(sdfp_pkg::REG_MAX_FIELDS, 8'd0);
		send_text("7.", 1'b1);

		for (int ph = 0; ph < 10; ph++) begin
			case (ph)
				0: begin wm = 1'b0; mf = 8'd255; end
				1: begin wm = 1'b1; mf = 8'd255; end
				2: begin wm = 1'b0; mf = 8'd1; end
				3: begin wm = 1'b1; mf = 8'd1; end
				default: begin
					wm = 1'($urandom_range(0, 1));
					case ($urandom_range(0, 3))
						0: mf = 8'($urandom_range(1, 255));
						1: mf = 8'd255;
						default: mf = 8'($urandom_range(1, 6));
					endcase
				end
			endcase
			wait_drained();
			write_reg(sdfp_pkg::REG_WORD_MODE, {7'd0, wm});
			write_reg(sdfp_pkg::REG_MAX_FIELDS, mf);
			if (ph == 2 || ph == 6)
				hold_requests <= hold_requests + 1;
			target = chars_sent + 100;
			while (chars_sent < target) begin
				if ($urandom_range(0, 7) == 0)
					send_noise();
				else
					send_record();
			end
			// sometimes leave a field or a closed record open across the next write
			case ($urandom_range(0, 3))
				0: for (int i = 0; i < $urandom_range(1, 5); i++)
					send_char(digit_char(), 1'b0);
				1: send_char(sdfp_pkg::CH_NEWLINE, 1'b0);
				default: ;
			endcase
		end

		s_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("separated_decimal_field_parser test passed");
		else
			$display("separated_decimal_field_parser test failed");
		$finish;
	end

endmodule

// ----- separated_decimal_field_parser.f -----
+incdir+rtl
rtl/sdfp_pkg.sv
rtl/sdfp_step.sv
rtl/sdfp_rq.sv
rtl/separated_decimal_field_parser.sv
tb/tb_separated_decimal_field_parser.sv
